### hdl/mavdt_pkg.sv
// Shared constants, types and configuration codes for the moving-average debounced trigger.
`timescale 1ns / 1ps

package mavdt_pkg;

  // Ring depth and field widths.
  localparam int unsigned WINDOW     = 100;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  // Division by WINDOW is a multiplication by a rounded-up reciprocal. With the
  // shift set to SUM_W plus the bit length of WINDOW the quotient is exact for
  // every sum that fits in SUM_W bits.
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int unsigned MULT_W      = SUM_W + 1;
  localparam int unsigned PROD_W      = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] RECIP_MULT =
    MULT_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_LEVEL = 2'd0,
    CFG_TRIGGER_ABOVE = 2'd1,
    CFG_DEBOUNCE_MS   = 2'd2
  } cfg_idx_e;

  localparam logic [LEVEL_W-1:0]    LEVEL_RST    = '0;
  localparam logic                  ABOVE_RST    = 1'b1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(100);

  typedef struct packed {
    logic [LEVEL_W-1:0]    level;
    logic                  above;
    logic [DEBOUNCE_W-1:0] debounce;
  } cfg_t;

  // Item after the ring update: the new window sum and its time stamp.
  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] now;
  } sum_stage_t;

  // Item after the division: the window average and its time stamp.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] avg;
    logic [TIME_W-1:0]   now;
  } avg_stage_t;

endpackage

### hdl/mavdt_window.sv
// Sample ring memory with running window sum and prefetched oldest entry.
`timescale 1ns / 1ps

module mavdt_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          advance_i,
  input  logic [mavdt_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [mavdt_pkg::TIME_W-1:0]   now_i,
  output mavdt_pkg::sum_stage_t          stage_o
);

  logic [mavdt_pkg::SAMPLE_W-1:0] ring_mem [mavdt_pkg::WINDOW];
  logic [mavdt_pkg::SAMPLE_W-1:0] rd_q;
  logic [mavdt_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic                           wrapped_q, wrapped_d;
  logic [mavdt_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [mavdt_pkg::SAMPLE_W-1:0] oldest;
  logic                           last_slot;
  logic                           stage_valid_q;
  logic [mavdt_pkg::SUM_W-1:0]    stage_sum_q;
  logic [mavdt_pkg::TIME_W-1:0]   stage_now_q;

  assign last_slot = (slot_q == mavdt_pkg::SLOT_W'(mavdt_pkg::WINDOW - 1));

  // Slots are filled in order, so until the first wrap the entry about to be
  // replaced has never been written and counts as zero.
  assign oldest = wrapped_q ? rd_q : '0;

  always_comb begin
    slot_d    = slot_q;
    wrapped_d = wrapped_q;
    sum_d     = sum_q;
    if (accept_i) begin
      slot_d    = last_slot ? '0 : slot_q + mavdt_pkg::SLOT_W'(1);
      wrapped_d = wrapped_q | last_slot;
      sum_d     = sum_q - mavdt_pkg::SUM_W'(oldest) + mavdt_pkg::SUM_W'(sample_i);
    end
  end

  // The read port always looks at the slot the next item will replace.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ring_mem[slot_q] <= sample_i;
    end
    if (accept_i && (slot_d == slot_q)) begin
      rd_q <= sample_i;
    end else begin
      rd_q <= ring_mem[slot_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q        <= '0;
      wrapped_q     <= 1'b0;
      sum_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      wrapped_q <= wrapped_d;
      sum_q     <= sum_d;
      if (advance_i) begin
        stage_valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_sum_q <= sum_d;
      stage_now_q <= now_i;
    end
  end

  // Packed in the field order of the stage type: valid, sum, time stamp.
  assign stage_o = {stage_valid_q, stage_sum_q, stage_now_q};

endmodule

### hdl/mavdt_average.sv
// Window average stage: divides the sum by the window length via a reciprocal multiply.
`timescale 1ns / 1ps

module mavdt_average (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  mavdt_pkg::sum_stage_t stage_i,
  output mavdt_pkg::avg_stage_t stage_o
);

  logic [mavdt_pkg::PROD_W-1:0]   product;
  logic                           stage_valid_q;
  logic [mavdt_pkg::SAMPLE_W-1:0] stage_avg_q;
  logic [mavdt_pkg::TIME_W-1:0]   stage_now_q;

  assign product = mavdt_pkg::PROD_W'(stage_i.sum) * mavdt_pkg::PROD_W'(mavdt_pkg::RECIP_MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (advance_i) begin
      stage_valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && stage_i.valid) begin
      stage_avg_q <= product[mavdt_pkg::RECIP_SHIFT +: mavdt_pkg::SAMPLE_W];
      stage_now_q <= stage_i.now;
    end
  end

  // Packed in the field order of the stage type: valid, average, time stamp.
  assign stage_o = {stage_valid_q, stage_avg_q, stage_now_q};

endmodule

### hdl/mavdt_debounce.sv
// Threshold compare, start-time latch and debounce decision with the result register.
`timescale 1ns / 1ps

module mavdt_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  mavdt_pkg::cfg_t                cfg_i,
  input  mavdt_pkg::avg_stage_t          stage_i,
  output logic                           valid_o,
  output logic [mavdt_pkg::SAMPLE_W-1:0] average_o,
  output logic                           detected_o
);

  logic                         armed_q, armed_d;
  logic [mavdt_pkg::TIME_W-1:0] start_q, start_d;
  logic [mavdt_pkg::TIME_W-1:0] elapsed;
  logic                         qualifies;
  logic                         det;
  logic                         take;
  logic                         valid_q;
  logic [mavdt_pkg::SAMPLE_W-1:0] average_q;
  logic                         detected_q;

  assign take      = advance_i && stage_i.valid;
  assign qualifies = ((stage_i.avg > cfg_i.level) == cfg_i.above);

  always_comb begin
    armed_d = armed_q;
    start_d = start_q;
    if (take) begin
      if (qualifies) begin
        armed_d = 1'b0;
        if (armed_q) begin
          start_d = stage_i.now;
        end
      end else begin
        armed_d = 1'b1;
      end
    end
  end

  // Elapsed time wraps modulo 2^32, matching the free-running time stamp.
  assign elapsed = stage_i.now - start_d;
  assign det     = qualifies && (elapsed > mavdt_pkg::TIME_W'(cfg_i.debounce));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      start_q <= '0;
      valid_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
      start_q <= start_d;
      if (advance_i) begin
        valid_q <= stage_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      average_q  <= stage_i.avg;
      detected_q <= det;
    end
  end

  assign valid_o    = valid_q;
  assign average_o  = average_q;
  assign detected_o = detected_q;

endmodule

### hdl/moving_average_debounced_trigger.sv
// Top level of the moving-average threshold trigger with time debounce.
`timescale 1ns / 1ps
//
//  Channel  | Signals                                    | Direction
//  ---------+--------------------------------------------+----------
//  input    | in_valid_i, in_ready_o, sample_i, now_ms_i | sink
//  result   | out_valid_o, out_ready_i, average_o,       | source
//           | detected_o                                 |
//  config   | cfg_we_i, cfg_index_i, cfg_data_i          | write only
//
// One transfer is taken every cycle while in_ready_o is high. The ring update and
// new sum are registered at the input transfer, the reciprocal multiply in the
// next stage and the debounce compare in the result register after that, which
// offers the result. The rate holds because the ring read-modify-write needs no
// extra read: the oldest ring entry is always prefetched from the memory port.
// Reset clears the sum, ring pointer, debounce state and configuration at once;
// no clearing pass is needed since unwritten ring slots are masked to zero.
// A stalled result register holds its value and back-pressure ripples up the
// three stages, so input is still taken while any stage has a free slot.

module moving_average_debounced_trigger (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mavdt_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [mavdt_pkg::TIME_W-1:0]     now_ms_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mavdt_pkg::SAMPLE_W-1:0]   average_o,
  output logic                             detected_o,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [mavdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mavdt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mavdt_pkg::cfg_t       cfg_q;
  mavdt_pkg::sum_stage_t sum_stage;
  mavdt_pkg::avg_stage_t avg_stage;
  logic                  out_en;
  logic                  avg_en;
  logic                  sum_en;
  logic                  accept;

  // Configuration registers. Writes to an index past the list are dropped,
  // and data bits above a register's width are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level    <= mavdt_pkg::LEVEL_RST;
      cfg_q.above    <= mavdt_pkg::ABOVE_RST;
      cfg_q.debounce <= mavdt_pkg::DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      unique case (mavdt_pkg::cfg_idx_e'(cfg_index_i))
        mavdt_pkg::CFG_TRIGGER_LEVEL: cfg_q.level    <= cfg_data_i[mavdt_pkg::LEVEL_W-1:0];
        mavdt_pkg::CFG_TRIGGER_ABOVE: cfg_q.above    <= cfg_data_i[0];
        mavdt_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce <= cfg_data_i[mavdt_pkg::DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves forward when the stage after it is empty or moving.
  assign out_en     = !out_valid_o || out_ready_i;
  assign avg_en     = !avg_stage.valid || out_en;
  assign sum_en     = !sum_stage.valid || avg_en;
  assign in_ready_o = sum_en;
  assign accept     = in_valid_i && sum_en;

  mavdt_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (sum_en),
    .sample_i  (sample_i),
    .now_i     (now_ms_i),
    .stage_o   (sum_stage)
  );

  mavdt_average u_average (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (avg_en),
    .stage_i   (sum_stage),
    .stage_o   (avg_stage)
  );

  mavdt_debounce u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (out_en),
    .cfg_i      (cfg_q),
    .stage_i    (avg_stage),
    .valid_o    (out_valid_o),
    .average_o  (average_o),
    .detected_o (detected_o)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the moving-average debounced trigger with a scoreboard.
`timescale 1ns / 1ps

module tb_top;

  // The run is split into phases. Before each one the pipeline is drained and the
  // three registers get new values. The first two phases use a sender that idles
  // often with a receiver that stalls even more, the next two swap the two rates,
  // and the last two run at full rate.
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 108;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned STIM_ROWS      = 22;

  // Short names for the register indexes, so the stimulus rows stay narrow.
  localparam logic [mavdt_pkg::CFG_IDX_W-1:0] IDX_LEVEL    = mavdt_pkg::CFG_TRIGGER_LEVEL;
  localparam logic [mavdt_pkg::CFG_IDX_W-1:0] IDX_ABOVE    = mavdt_pkg::CFG_TRIGGER_ABOVE;
  localparam logic [mavdt_pkg::CFG_IDX_W-1:0] IDX_DEBOUNCE = mavdt_pkg::CFG_DEBOUNCE_MS;
  localparam logic [mavdt_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [mavdt_pkg::SAMPLE_W-1:0] average;
    logic                           detected;
  } avg_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed part: either a sample transfer or a register write.
  // Rows with "typed" set carry a hand-computed expectation; the rest are
  // checked against the window predictor.
  typedef struct packed {
    row_kind_e                        kind;
    logic [mavdt_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [mavdt_pkg::CFG_DATA_W-1:0] reg_data;
    logic [mavdt_pkg::SAMPLE_W-1:0]   smp;
    logic [mavdt_pkg::TIME_W-1:0]     stamp;
    logic                             typed;
    avg_result_t                      want;
  } stim_row_t;

  // The directed rows walk through reset state, a ramp from an empty window,
  // the debounce boundary, a time stamp going backwards, a 32-bit time wrap,
  // zero and maximum debounce lengths, both polarities, data bits above a
  // register's width, a write to an index past the register list, and a level
  // change while the detector is active.
  stim_row_t stim_rows [STIM_ROWS] = '{
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'h0000_0000, 1'b1, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd1023, 32'h0000_0005, 1'b1, '{10'd10, 1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd1023, 32'h0000_0069, 1'b1, '{10'd20, 1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd1023, 32'h0000_006A, 1'b1, '{10'd30, 1'b1}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'hFFFF_FFF0, 1'b1, '{10'd30, 1'b1}},
    '{ROW_CFG,  IDX_LEVEL,     16'hFFFF, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd5,    32'hFFFF_FFF0, 1'b1, '{10'd30, 1'b0}},
    '{ROW_CFG,  IDX_ABOVE,     16'hFFFE, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'hFFFF_FFF0, 1'b1, '{10'd30, 1'b0}},
    '{ROW_CFG,  IDX_DEBOUNCE,  16'h0000, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'hFFFF_FFF0, 1'b1, '{10'd30, 1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'h0000_0000, 1'b1, '{10'd30, 1'b1}},
    '{ROW_CFG,  IDX_DEBOUNCE,  16'hFFFF, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'h0000_FFEF, 1'b1, '{10'd30, 1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd0,    32'h0000_FFF0, 1'b1, '{10'd30, 1'b1}},
    '{ROW_CFG,  CFG_IDX_SPARE, 16'hFFFF, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'd1023, 32'hFFFF_FFFF, 1'b1, '{10'd40, 1'b0}},
    '{ROW_CFG,  IDX_LEVEL,     16'hFC15, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_CFG,  IDX_ABOVE,     16'h0001, 10'd0,    32'h0000_0000, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'h2AA,  32'hAAAA_AAAA, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'h155,  32'h5555_5555, 1'b0, '{10'd0,  1'b0}},
    '{ROW_ITEM, IDX_LEVEL,     16'h0000, 10'h3FF,  32'h5555_5556, 1'b0, '{10'd0,  1'b0}}
  };

  logic                             clk_i;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_ready_o;
  logic [mavdt_pkg::SAMPLE_W-1:0]   sample_i    = '0;
  logic [mavdt_pkg::TIME_W-1:0]     now_ms_i    = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [mavdt_pkg::SAMPLE_W-1:0]   average_o;
  logic                             detected_o;
  logic                             cfg_we_i    = 1'b0;
  logic [mavdt_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mavdt_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned send_idle_pct  = 38;
  int unsigned recv_stall_pct = 78;
  int unsigned mismatch_count = 0;

  // Predictor state: the sample ring, its write pointer and running total, the
  // arming flag with the latched start time, and the shadow register values.
  logic [mavdt_pkg::SAMPLE_W-1:0]   ring_model [mavdt_pkg::WINDOW];
  logic [mavdt_pkg::SLOT_W-1:0]     ring_ptr     = '0;
  logic [mavdt_pkg::SUM_W-1:0]      ring_total   = '0;
  logic                             arm_flag     = 1'b1;
  logic [mavdt_pkg::TIME_W-1:0]     hold_start   = '0;
  logic [mavdt_pkg::LEVEL_W-1:0]    cfg_level    = mavdt_pkg::LEVEL_RST;
  logic                             cfg_above    = mavdt_pkg::ABOVE_RST;
  logic [mavdt_pkg::DEBOUNCE_W-1:0] cfg_debounce = mavdt_pkg::DEBOUNCE_RST;

  // Results still owed by the block, oldest first.
  avg_result_t pending_results [$];

  moving_average_debounced_trigger u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o),
    .detected_o  (detected_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (ring_model[i]) ring_model[i] = '0;
  end

  // Pushes one sample through the ring, updates the debounce state and returns
  // the average and detect flag that the block must report for it.
  function automatic avg_result_t advance_window(input logic [mavdt_pkg::SAMPLE_W-1:0] smp,
                                                 input logic [mavdt_pkg::TIME_W-1:0] stamp);
    avg_result_t res;
    int unsigned quotient;
    logic [mavdt_pkg::TIME_W-1:0] elapsed;
    logic qualifies;
    ring_total = ring_total - mavdt_pkg::SUM_W'(ring_model[ring_ptr])
               + mavdt_pkg::SUM_W'(smp);
    ring_model[ring_ptr] = smp;
    ring_ptr = (ring_ptr == mavdt_pkg::SLOT_W'(mavdt_pkg::WINDOW - 1)) ?
               '0 : ring_ptr + mavdt_pkg::SLOT_W'(1);
    quotient = 32'(ring_total) / mavdt_pkg::WINDOW;
    res.average = quotient[mavdt_pkg::SAMPLE_W-1:0];
    qualifies = ((res.average > cfg_level) == cfg_above);
    res.detected = 1'b0;
    if (qualifies) begin
      if (arm_flag) begin
        hold_start = stamp;
        arm_flag = 1'b0;
      end
      // The elapsed time is a modular 32-bit difference, so a wrap of the
      // millisecond counter is harmless and a step backwards looks huge.
      elapsed = stamp - hold_start;
      res.detected = (elapsed > mavdt_pkg::TIME_W'(cfg_debounce));
    end else begin
      arm_flag = 1'b1;
    end
    return res;
  endfunction

  // Offers one sample, possibly after a random gap, and waits for its transfer.
  // The valid line only drops during a gap, so back-to-back items keep it high.
  task automatic push_sample(input logic [mavdt_pkg::SAMPLE_W-1:0] smp,
                             input logic [mavdt_pkg::TIME_W-1:0] stamp,
                             input logic typed, input avg_result_t given);
    avg_result_t modeled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    now_ms_i   <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    modeled = advance_window(smp, stamp);
    pending_results.push_back(typed ? given : modeled);
  endtask

  // Drops valid, waits for every owed result and lets the pipeline go quiet.
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register and mirrors the write into the shadow copy. Bits above
  // a register's width are dropped and an index past the list changes nothing.
  // The wait after dropping the write enable keeps two writes from sharing a time step.
  task automatic cfg_write(input logic [mavdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mavdt_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    unique case (idx)
      IDX_LEVEL:    cfg_level = data[mavdt_pkg::LEVEL_W-1:0];
      IDX_ABOVE:    cfg_above = data[0];
      IDX_DEBOUNCE: cfg_debounce = data[mavdt_pkg::DEBOUNCE_W-1:0];
      default: ;
    endcase
  endtask

  // The receiver: every result transfer is compared with the oldest expectation,
  // and the ready line is redrawn at every edge.
  always @(posedge clk_i) begin : result_monitor
    avg_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: average=%0d detected=%0b",
               average_o, detected_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (average_o !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, average_o);
          mismatch_count++;
        end
        if (detected_o !== want.detected) begin
          $error("detected: expected %0b, actual %0b", want.detected, detected_o);
          mismatch_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    logic [mavdt_pkg::SAMPLE_W-1:0]   smp;
    logic [mavdt_pkg::TIME_W-1:0]     stamp;
    logic [mavdt_pkg::LEVEL_W-1:0]    lvl;
    logic [mavdt_pkg::DEBOUNCE_W-1:0] dbn;
    logic                             abv;
    logic                             run_high;
    int unsigned                      roll;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run under the first idling pattern.
    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        settle_pipeline();
        cfg_write(stim_rows[r].reg_idx, stim_rows[r].reg_data);
      end else begin
        push_sample(stim_rows[r].smp, stim_rows[r].stamp, stim_rows[r].typed,
                    stim_rows[r].want);
      end
    end

    // Random part. The samples follow a high or a low run that flips now and
    // then, so the window average drifts across the level and the detector arms,
    // latches and re-arms many times. Time mostly creeps forward by a few
    // milliseconds so the debounce length matters, with rare random jumps.
    run_high = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      settle_pipeline();
      unique case (p / 2)
        0: begin
          send_idle_pct  = 38;
          recv_stall_pct = 78;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      // The first and last phases pin the level to its extremes; the middle
      // ones put it where the drifting average will cross it.
      if (p == 0)
        lvl = '0;
      else if (p == PHASES - 1)
        lvl = '1;
      else
        lvl = mavdt_pkg::LEVEL_W'($urandom_range(300, 700));
      abv = (p == PHASES - 1) ? 1'b0 : ((p == 0) ? 1'b1 : p[0]);
      if (p == 1)
        dbn = '0;
      else if (p == 4)
        dbn = '1;
      else
        dbn = mavdt_pkg::DEBOUNCE_W'($urandom_range(0, 60));

      cfg_write(IDX_LEVEL, {6'($urandom), lvl});
      cfg_write(IDX_ABOVE, {15'($urandom), abv});
      cfg_write(IDX_DEBOUNCE, dbn);

      stamp = (p == 3) ? 32'hFFFF_FF80 : $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 4) run_high = !run_high;
        roll = $urandom_range(0, 99);
        if (roll < 15)
          smp = mavdt_pkg::SAMPLE_W'($urandom);
        else if (run_high)
          smp = mavdt_pkg::SAMPLE_W'($urandom_range(700, 1023));
        else
          smp = mavdt_pkg::SAMPLE_W'($urandom_range(0, 300));
        if ($urandom_range(0, 99) < 2)
          stamp = $urandom;
        else
          stamp = stamp + $urandom_range(0, 6);
        push_sample(smp, stamp, 1'b0, '0);
      end
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
hdl/mavdt_pkg.sv
hdl/mavdt_window.sv
hdl/mavdt_average.sv
hdl/mavdt_debounce.sv
hdl/moving_average_debounced_trigger.sv
tb/sv/tb_top.sv
